// File: rtl/cmt_pkg.sv
// shared types and constants for the circle merge table
package cmt_pkg;

   localparam int CoordWidth  = 16;
   localparam int RadiusWidth = 10;
   localparam int OffsetWidth = 10;
   localparam int LimitWidth  = RadiusWidth + 1;
   localparam int DataWidth   = 48;
   localparam int UserWidth   = 2;

   typedef struct packed {
      logic [RadiusWidth-1:0] r;
      logic [CoordWidth-1:0]  y;
      logic [CoordWidth-1:0]  x;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic live;
   } step_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS,
      ST_UPDATE,
      ST_FLUSH
   } state_type;

endpackage

// File: rtl/cmt_cell.sv
// one table cell: holds an entry, shifts from its neighbour or loads an appended circle
module cmt_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  cmt_pkg::entry_type shift_in,
   input  logic               load_en,
   input  cmt_pkg::entry_type load_in,
   output cmt_pkg::entry_type q
);
   import cmt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_in;
      end else if (shift_en) begin
         entry_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

// File: rtl/cmt_merge.sv
// compare and merge unit in the ring between the head and tail cells
module cmt_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  cmt_pkg::step_type                step,
   input  cmt_pkg::entry_type               circle,
   input  logic [cmt_pkg::OffsetWidth-1:0]  offset,
   input  cmt_pkg::entry_type               head,
   output cmt_pkg::entry_type               tail,
   output logic                             hit
);
   import cmt_pkg::*;

   // stage a: distances and limit
   entry_type              a_entry_ff, a_entry_in;
   logic [CoordWidth-1:0]  a_dx_ff, a_dx_in;
   logic [CoordWidth-1:0]  a_dy_ff, a_dy_in;
   logic [LimitWidth-1:0]  a_lim_ff, a_lim_in;
   logic                   a_live_ff, a_live_in;
   // stage b: squares
   entry_type               b_entry_ff, b_entry_in;
   logic [2*CoordWidth-1:0] b_dx2_ff, b_dx2_in;
   logic [2*CoordWidth-1:0] b_dy2_ff, b_dy2_in;
   logic [2*LimitWidth-1:0] b_lim2_ff, b_lim2_in;
   logic                    b_live_ff, b_live_in;

   logic [2*CoordWidth:0]   dist2;
   logic                    match;
   logic [CoordWidth:0]     sum_x;
   logic [CoordWidth:0]     sum_y;
   logic [RadiusWidth:0]    sum_r;
   entry_type               mean;

   always_comb begin
      a_entry_in = head;
      a_dx_in    = (circle.x >= head.x) ? circle.x - head.x : head.x - circle.x;
      a_dy_in    = (circle.y >= head.y) ? circle.y - head.y : head.y - circle.y;
      a_lim_in   = {1'b0, head.r} + {1'b0, offset};
      a_live_in  = step.live;
      b_entry_in = a_entry_ff;
      b_dx2_in   = {{CoordWidth{1'b0}}, a_dx_ff} * {{CoordWidth{1'b0}}, a_dx_ff};
      b_dy2_in   = {{CoordWidth{1'b0}}, a_dy_ff} * {{CoordWidth{1'b0}}, a_dy_ff};
      b_lim2_in  = {{LimitWidth{1'b0}}, a_lim_ff} * {{LimitWidth{1'b0}}, a_lim_ff};
      b_live_in  = a_live_ff;
   end

   always_ff @(posedge clock) begin
      if (step.shift) begin
         a_entry_ff <= a_entry_in;
         a_dx_ff    <= a_dx_in;
         a_dy_ff    <= a_dy_in;
         a_lim_ff   <= a_lim_in;
         b_entry_ff <= b_entry_in;
         b_dx2_ff   <= b_dx2_in;
         b_dy2_ff   <= b_dy2_in;
         b_lim2_ff  <= b_lim2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_live_ff <= 1'b0;
         b_live_ff <= 1'b0;
      end else if (step.shift) begin
         a_live_ff <= a_live_in;
         b_live_ff <= b_live_in;
      end
   end

   always_comb begin
      dist2  = {1'b0, b_dx2_ff} + {1'b0, b_dy2_ff};
      match  = dist2 <= {{(2*CoordWidth+1-2*LimitWidth){1'b0}}, b_lim2_ff};
      sum_x  = {1'b0, circle.x} + {1'b0, b_entry_ff.x};
      sum_y  = {1'b0, circle.y} + {1'b0, b_entry_ff.y};
      sum_r  = {1'b0, circle.r} + {1'b0, b_entry_ff.r};
      mean.x = sum_x[CoordWidth:1];
      mean.y = sum_y[CoordWidth:1];
      mean.r = sum_r[RadiusWidth:1];
      hit    = b_live_ff & match;
      tail   = hit ? mean : b_entry_ff;
   end

endmodule

// File: rtl/circle_merge_table.sv
// top level of the circle merge table: cell ring, merge unit, control and output register
//
//  chan | dir | handshake         | word (lowest field first)
//  req_ | in  | req_tvalid/tready | x, y, radius; user valid_circle; last end_of_frame
//  rsp_ | out | rsp_tvalid/tready | x, y, radius; user table_empty, overflowed; last last_result
//  csr_ | in  | csr_valid/ready   | merge_offset
//
//  a circle is accepted while idle, makes one full turn of the ring through the compare
//  unit in the pass state and is appended in the update state if nothing matched and there is room
//  a flush gives one word a cycle while rsp_tready is high; an empty flush gives one word
//  synchronous reset clears count, overflow flag, offset and control, not the entries
//  req_tready is high only while idle; a stalled output holds the flush in place
module circle_merge_table #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cmt_pkg::DataWidth-1:0]      req_tdata,  // center_x, center_y, radius
   input  logic                               req_tuser,  // valid_circle
   input  logic                               req_tlast,  // end_of_frame
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cmt_pkg::DataWidth-1:0]      rsp_tdata,  // out_x, out_y, out_radius
   output logic [cmt_pkg::UserWidth-1:0]      rsp_tuser,  // table_empty, overflowed
   output logic                               rsp_tlast,  // last_result
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cmt_pkg::OffsetWidth-1:0]    csr_data
);
   import cmt_pkg::*;

   localparam int CW      = $clog2(TABLE_DEPTH + 1);
   localparam int RingLen = TABLE_DEPTH + 2;
   localparam int TW      = $clog2(RingLen);
   localparam int WW      = (TW > CW) ? TW : CW;
   localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
   localparam logic [TW-1:0] PassEnd = TW'(RingLen - 1);
   localparam int EntryBits = 2 * CoordWidth + RadiusWidth;

   state_type state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   overflow_ff, overflow_in;
   logic [OffsetWidth-1:0] offset_ff, offset_in;
   logic [TW-1:0]          pass_ff, pass_in;
   logic [CW-1:0]          flush_ff, flush_in;
   logic                   hit_ff, hit_in;
   entry_type              circle_ff, circle_in;
   logic                   eof_ff, eof_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0]   rsp_data_ff, rsp_data_in;
   logic [UserWidth-1:0]   rsp_user_ff, rsp_user_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic      req_take;
   logic      out_free;
   logic      emit;
   logic      last_word;
   logic      shift_en;
   logic      load_en;
   logic      unit_hit;
   step_type  step;
   entry_type cell_q [TABLE_DEPTH];
   entry_type tail;

   assign req_take  = req_tvalid & req_tready;
   assign out_free  = ~rsp_valid_ff | rsp_tready;
   assign last_word = (count_ff == '0) || (CW'(flush_ff + 1'b1) == count_ff);
   assign csr_ready = 1'b1;

   // ring of cells, head at index 0, tail fed by the merge unit
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type nb;
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign nb = tail;
      end else begin : g_mid
         assign nb = cell_q[i+1];
      end
      cmt_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .shift_in (nb),
         .load_en  (load_en && (count_ff == CW'(i))),
         .load_in  (circle_ff),
         .q        (cell_q[i])
      );
   end

   cmt_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .circle (circle_ff),
      .offset (offset_ff),
      .head   (cell_q[0]),
      .tail   (tail),
      .hit    (unit_hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_tuser) begin
                  state_in = ST_PASS;
               end else if (req_tlast) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_PASS: begin
            if (pass_ff == PassEnd) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = eof_ff ? ST_FLUSH : ST_IDLE;
         end
         ST_FLUSH: begin
            if (emit && last_word) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      emit       = 1'b0;
      shift_en   = 1'b0;
      load_en    = 1'b0;
      step.live  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_PASS: begin
            shift_en  = 1'b1;
            step.live = WW'(pass_ff) < WW'(count_ff);
         end
         ST_UPDATE: begin
            load_en = ~hit_ff && (count_ff < DepthC);
         end
         ST_FLUSH: begin
            emit     = out_free;
            shift_en = out_free && (count_ff != '0);
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      step.shift = shift_en;
   end

   // datapath registers
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      offset_in   = csr_valid ? csr_data : offset_ff;
      pass_in     = pass_ff;
      flush_in    = flush_ff;
      hit_in      = hit_ff;
      circle_in   = circle_ff;
      eof_in      = eof_ff;
      if (req_take) begin
         circle_in.x = req_tdata[CoordWidth-1:0];
         circle_in.y = req_tdata[2*CoordWidth-1:CoordWidth];
         circle_in.r = req_tdata[EntryBits-1:2*CoordWidth];
         eof_in      = req_tlast;
         pass_in     = '0;
         flush_in    = '0;
         hit_in      = 1'b0;
      end
      if (state_ff == ST_PASS) begin
         pass_in = TW'(pass_ff + 1'b1);
         if (unit_hit) begin
            hit_in = 1'b1;
         end
      end
      if (state_ff == ST_UPDATE && !hit_ff) begin
         if (count_ff < DepthC) begin
            count_in = CW'(count_ff + 1'b1);
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (emit) begin
         flush_in = CW'(flush_ff + 1'b1);
         if (last_word) begin
            count_in = '0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = last_word;
         if (count_ff == '0) begin
            rsp_data_in = '0;
            rsp_user_in = {overflow_ff, 1'b1};
         end else begin
            rsp_data_in = {{(DataWidth-EntryBits){1'b0}}, cell_q[0].r, cell_q[0].y,
                           cell_q[0].x};
            rsp_user_in = {overflow_ff, 1'b0};
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         offset_ff    <= '0;
         pass_ff      <= '0;
         flush_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         offset_ff    <= offset_in;
         pass_ff      <= pass_in;
         flush_ff     <= flush_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      circle_ff   <= circle_in;
      eof_ff      <= eof_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC)
      else $error("entry count beyond table depth");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      load_en |-> (count_ff < DepthC) && !hit_ff)
      else $error("append into a full table or after a merge");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(overflow_ff))
      else $error("overflow flag cleared");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS) |-> (pass_ff <= PassEnd))
      else $error("ring pass counter out of range");

   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (emit && last_word) |=> (state_ff == ST_IDLE) && (count_ff == '0) && rsp_tlast)
      else $error("flush did not close cleanly");
`endif

endmodule
